// File: src/lpts_pkg.sv
// Shared constants, result type and character-class helpers for the log
// timestamp prefix stripper. No dependencies.
package lpts_pkg;

	localparam int MAX_MESSAGE_BYTES = 1024;
	// The position counter saturates at one past the maximum length.
	localparam int POS_W    = $clog2(MAX_MESSAGE_BYTES + 2);
	localparam int BYTE_W   = 8;
	localparam int OFFSET_W = 10;
	localparam int MODE_W   = 2;

	localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SYSLOG = 2'd1;
	localparam logic [MODE_W-1:0] MODE_ISO    = 2'd2;

	localparam int SYSLOG_MIN_LEN = 16;
	localparam int ISO_PREFIX_LEN = 19;
	localparam int ISO_MIN_LEN    = 20;

	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
	localparam logic [BYTE_W-1:0] CH_DASH  = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_T     = 8'h54;
	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
	localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

	// Month abbreviations, three characters each, first character in the top byte.
	localparam logic [23:0] MONTHS [12] = '{
		24'h4A616E, 24'h466562, 24'h4D6172, 24'h417072,
		24'h4D6179, 24'h4A756E, 24'h4A756C, 24'h417567,
		24'h536570, 24'h4F6374, 24'h4E6F76, 24'h446563
	};

	typedef struct packed {
		logic [OFFSET_W-1:0] payload_offset;
		logic                stripped;
		logic                too_long;
	} result_t;

	function automatic logic is_digit(logic [BYTE_W-1:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

	function automatic logic is_white(logic [BYTE_W-1:0] b);
		return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
	endfunction

	function automatic logic month_ok(logic [15:0] first_two, logic [BYTE_W-1:0] b);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < 12; i++) begin
			if (MONTHS[i] == {first_two, b})
				hit = 1'b1;
		end
		return hit;
	endfunction

endpackage

// File: src/lpts_ifs.sv
// Handshake channel interfaces of the log timestamp prefix stripper: message
// bytes in, results out, and the mode register write. Depends on lpts_pkg.
interface lpts_byte_if;
	logic                        valid;
	logic                        ready;
	logic [lpts_pkg::BYTE_W-1:0] message_byte;
	logic                        last_byte;

	modport source (output valid, output message_byte, output last_byte, input ready);
	modport sink (input valid, input message_byte, input last_byte, output ready);
endinterface

interface lpts_result_if;
	logic                          valid;
	logic                          ready;
	logic [lpts_pkg::OFFSET_W-1:0] payload_offset;
	logic                          stripped;
	logic                          too_long;

	modport source (output valid, output payload_offset, output stripped,
		output too_long, input ready);
	modport sink (input valid, input payload_offset, input stripped,
		input too_long, output ready);
endinterface

interface lpts_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [lpts_pkg::MODE_W-1:0] date_mode;

	modport source (output valid, output date_mode, input ready);
	modport sink (input valid, input date_mode, output ready);
endinterface

// File: src/lpts_scan.sv
// Per-message scan state of the prefix stripper: prefix check, payload search
// and the result for the last byte. Depends on lpts_pkg.
module lpts_scan (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic                          clear,
	input  logic [lpts_pkg::MODE_W-1:0]   mode,
	input  logic [lpts_pkg::BYTE_W-1:0]   byte_in,
	input  logic                          last_in,
	output lpts_pkg::result_t             result
);

	typedef enum logic [2:0] {
		PH_PREFIX,
		PH_LEAD,
		PH_WORD,
		PH_GAP,
		PH_FOUND
	} phase_t;

	localparam logic [lpts_pkg::POS_W-1:0] POS_SAT =
		lpts_pkg::POS_W'(lpts_pkg::MAX_MESSAGE_BYTES + 1);

	logic [lpts_pkg::POS_W-1:0]    pos_q;
	phase_t                        phase_q;
	logic [15:0]                   month_q;
	logic                          valid_q;
	logic [lpts_pkg::OFFSET_W-1:0] cand_q;
	logic                          found_q;

	logic [lpts_pkg::POS_W-1:0]    pos_n;
	phase_t                        phase_n;
	phase_t                        sys_phase;
	logic [15:0]                   month_n;
	logic                          valid_n;
	logic [lpts_pkg::OFFSET_W-1:0] cand_n;
	logic                          found_n;
	logic                          ok;
	logic                          too;
	logic                          long_enough;

	always_comb begin
		phase_n   = phase_q;
		month_n   = month_q;
		valid_n   = valid_q;
		cand_n    = cand_q;
		found_n   = found_q;
		ok        = 1'b1;
		sys_phase = phase_q;

		if (mode == lpts_pkg::MODE_SYSLOG) begin
			if (pos_q < lpts_pkg::POS_W'(lpts_pkg::SYSLOG_MIN_LEN)) begin
				case (pos_q[3:0])
					4'd0, 4'd1: month_n = {month_q[7:0], byte_in};
					4'd2: ok = lpts_pkg::month_ok(month_q, byte_in);
					4'd4, 4'd5: ok = lpts_pkg::is_digit(byte_in) || (byte_in == lpts_pkg::CH_SPACE);
					4'd3, 4'd6, 4'd15: ok = (byte_in == lpts_pkg::CH_SPACE);
					4'd9, 4'd12: ok = (byte_in == lpts_pkg::CH_COLON);
					default: ok = lpts_pkg::is_digit(byte_in);
				endcase
				if (!ok)
					valid_n = 1'b0;
			end else begin
				if (phase_q == PH_PREFIX)
					sys_phase = PH_LEAD;
				phase_n = sys_phase;
				case (sys_phase)
					PH_LEAD: phase_n = (byte_in == lpts_pkg::CH_SPACE) ? PH_LEAD : PH_WORD;
					PH_WORD: begin
						if (byte_in == lpts_pkg::CH_SPACE)
							phase_n = PH_GAP;
					end
					PH_GAP: begin
						if (byte_in != lpts_pkg::CH_SPACE) begin
							phase_n = PH_FOUND;
							cand_n  = lpts_pkg::OFFSET_W'(pos_q);
							found_n = 1'b1;
						end
					end
					default: ;
				endcase
			end
		end else if (mode == lpts_pkg::MODE_ISO) begin
			if (pos_q < lpts_pkg::POS_W'(lpts_pkg::ISO_PREFIX_LEN)) begin
				case (pos_q[4:0])
					5'd4, 5'd7: ok = (byte_in == lpts_pkg::CH_DASH);
					5'd10: ok = (byte_in == lpts_pkg::CH_T) || (byte_in == lpts_pkg::CH_SPACE);
					5'd13, 5'd16: ok = (byte_in == lpts_pkg::CH_COLON);
					default: ok = lpts_pkg::is_digit(byte_in);
				endcase
				if (!ok)
					valid_n = 1'b0;
			end
			// The payload search runs from the first byte, alongside the check.
			if (phase_q == PH_PREFIX) begin
				if (lpts_pkg::is_white(byte_in)) begin
					if (byte_in == lpts_pkg::CH_SPACE) begin
						phase_n = PH_GAP;
					end else begin
						phase_n = PH_FOUND;
						cand_n  = lpts_pkg::OFFSET_W'(pos_q);
						found_n = 1'b1;
					end
				end
			end else if (phase_q == PH_GAP) begin
				if (byte_in != lpts_pkg::CH_SPACE) begin
					phase_n = PH_FOUND;
					cand_n  = lpts_pkg::OFFSET_W'(pos_q);
					found_n = 1'b1;
				end
			end
		end

		pos_n = (pos_q == POS_SAT) ? pos_q : pos_q + 1'b1;
		too   = pos_n > lpts_pkg::POS_W'(lpts_pkg::MAX_MESSAGE_BYTES);
		long_enough =
			((mode == lpts_pkg::MODE_SYSLOG) &&
				(pos_n >= lpts_pkg::POS_W'(lpts_pkg::SYSLOG_MIN_LEN))) ||
			((mode == lpts_pkg::MODE_ISO) &&
				(pos_n >= lpts_pkg::POS_W'(lpts_pkg::ISO_MIN_LEN)));

		result.stripped       = !too && valid_n && found_n && long_enough;
		result.payload_offset = result.stripped ? cand_n : '0;
		result.too_long       = too;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			phase_q <= PH_PREFIX;
			month_q <= '0;
			valid_q <= 1'b1;
			cand_q  <= '0;
			found_q <= 1'b0;
		end else if (clear || (step && last_in)) begin
			pos_q   <= '0;
			phase_q <= PH_PREFIX;
			month_q <= '0;
			valid_q <= 1'b1;
			cand_q  <= '0;
			found_q <= 1'b0;
		end else if (step) begin
			pos_q   <= pos_n;
			phase_q <= phase_n;
			month_q <= month_n;
			valid_q <= valid_n;
			cand_q  <= cand_n;
			found_q <= found_n;
		end
	end

endmodule

// File: src/log_timestamp_prefix_stripper.sv
// Top level of the log timestamp prefix stripper: input register, scan state
// and result register. Depends on lpts_pkg, lpts_ifs and lpts_scan.
// Throughput: one message byte per cycle, across message ends too, while results are taken.
// Result path: the last byte of a message enters the input register, and its result
// enters the result register when that byte advances, which waits on a full result register.
// Reset: arst_n clears both valid flags, the scan state and date_mode (which reads 0).
module log_timestamp_prefix_stripper (
	input logic         clk,
	input logic         arst_n,
	lpts_byte_if.sink   msg,
	lpts_result_if.source res,
	lpts_cfg_if.sink    cfg
);

	// Mode register. Writes must arrive only while the block is idle; the block itself
	// does not enforce this. The port is always ready, and a write also restarts the message state.
	logic [lpts_pkg::MODE_W-1:0] date_mode_q;
	logic                        cfg_write;

	// Input register: the accepted item waits here until it advances into the scan state.
	logic                        valid_s1;
	logic [lpts_pkg::BYTE_W-1:0] byte_s1;
	logic                        last_s1;

	// Result register.
	logic                        res_valid_q;
	lpts_pkg::result_t           res_q;

	lpts_pkg::result_t           scan_result;
	logic                        advance;

	assign cfg.ready = 1'b1;
	assign cfg_write = cfg.valid;

	// An item in the input register moves on whenever it produces no result, or
	// when the result register is empty or being emptied in this cycle. The
	// input register refills in the same cycle, so bytes stream back to back.
	assign advance   = valid_s1 && (!last_s1 || !res_valid_q || res.ready);
	assign msg.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			date_mode_q <= lpts_pkg::MODE_NONE;
		end else if (cfg_write) begin
			date_mode_q <= cfg.date_mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (msg.ready) begin
			valid_s1 <= msg.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (msg.valid && msg.ready) begin
			byte_s1 <= msg.message_byte;
			last_s1 <= msg.last_byte;
		end
	end

	// The scan state advances once for every byte leaving the input register
	// and produces the result combinationally for a final byte.
	lpts_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.clear   (cfg_write),
		.mode    (date_mode_q),
		.byte_in (byte_s1),
		.last_in (last_s1),
		.result  (scan_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			res_q <= scan_result;
		end
	end

	assign res.valid          = res_valid_q;
	assign res.payload_offset = res_q.payload_offset;
	assign res.stripped       = res_q.stripped;
	assign res.too_long       = res_q.too_long;

endmodule
